@@ rtl/frac_pkg.sv @@
// Shared types and constants for the fraction arithmetic block.
`timescale 1ns / 1ps
package frac_pkg;

	localparam int OPERAND_BITS_DEF = 16;
	localparam int FIELD_W          = 16;
	localparam int NUM_W            = 32;
	localparam int DEN_W            = 30;

	localparam logic [DEN_W-1:0] DEN_MAX = '1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_ZERO_DEN = 1'b1;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_MUL = 2'd2,
		KIND_DIV = 2'd3
	} frac_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_NUM,
		ST_MUL_CROSS,
		ST_MUL_DEN,
		ST_COMBINE,
		ST_GCD,
		ST_DIV,
		ST_FINISH
	} frac_state_t;

	typedef enum logic [1:0] {
		MUL_NUM,
		MUL_CROSS,
		MUL_DEN
	} frac_mul_sel_t;

	typedef struct packed {
		frac_kind_t              kind;
		logic signed [FIELD_W-1:0] left_num;
		logic signed [FIELD_W-1:0] left_den;
		logic signed [FIELD_W-1:0] right_num;
		logic signed [FIELD_W-1:0] right_den;
	} frac_req_t;

	typedef struct packed {
		logic signed [NUM_W-1:0] result_num;
		logic [DEN_W-1:0]        result_den;
		logic                    status;
	} frac_rsp_t;

	typedef struct packed {
		logic          load_in;
		logic          mul_en;
		frac_mul_sel_t mul_sel;
		logic          combine;
		logic          gcd_step;
		logic          div_start;
		logic          div_step;
		logic          out_load;
	} frac_cmd_t;

	typedef struct packed {
		frac_kind_t kind;
		logic       den_zero;
		logic       gcd_done;
		logic       div_last;
	} frac_stat_t;

endpackage

@@ rtl/frac_ctrl.sv @@
// Sequencing state machine for the fraction arithmetic block.
`timescale 1ns / 1ps
module frac_ctrl import frac_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       out_stall,
	output logic       out_valid,
	input  frac_stat_t stat,
	output frac_cmd_t  cmd
);

	frac_state_t state_q, state_nxt;
	logic        out_valid_q;
	logic        out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_MUL_NUM;
			end
			ST_MUL_NUM: begin
				if (stat.kind == KIND_ADD || stat.kind == KIND_SUB) state_nxt = ST_MUL_CROSS;
				else state_nxt = ST_MUL_DEN;
			end
			ST_MUL_CROSS: state_nxt = ST_MUL_DEN;
			ST_MUL_DEN:   state_nxt = ST_COMBINE;
			ST_COMBINE: begin
				state_nxt = stat.den_zero ? ST_FINISH : ST_GCD;
			end
			ST_GCD: begin
				if (stat.gcd_done) state_nxt = ST_DIV;
			end
			ST_DIV: begin
				if (stat.div_last) state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = MUL_NUM;
		unique case (state_q)
			ST_IDLE:      cmd.load_in = in_valid;
			ST_MUL_NUM: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_NUM;
			end
			ST_MUL_CROSS: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_CROSS;
			end
			ST_MUL_DEN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DEN;
			end
			ST_COMBINE:   cmd.combine = 1'b1;
			ST_GCD: begin
				cmd.gcd_step  = !stat.gcd_done;
				cmd.div_start = stat.gcd_done;
			end
			ST_DIV:       cmd.div_step = 1'b1;
			ST_FINISH:    cmd.out_load = out_free;
			default:      cmd.load_in = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_MUL_NUM))
		else $error("accepted request did not start the multiply sequence");

	a_valid_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result became valid outside the finish step");

	a_no_load_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && out_valid_q) |-> !out_stall)
		else $error("result register overwritten while stalled");

endmodule

@@ rtl/frac_dp.sv @@
// Datapath: operand capture, shared multiplier, binary GCD and two-lane divider.
`timescale 1ns / 1ps
module frac_dp import frac_pkg::*; #(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  frac_req_t  req,
	input  frac_cmd_t  cmd,
	output frac_stat_t stat,
	output frac_rsp_t  rsp
);

	localparam int B  = OPERAND_BITS;
	localparam int W  = 2 * B;
	localparam int KW = $clog2(W);
	localparam int XW = (W > NUM_W) ? W : NUM_W;

	localparam int IX_LN = 0;
	localparam int IX_LD = 1;
	localparam int IX_RN = 2;
	localparam int IX_RD = 3;

	// operand capture, kept as sign and magnitude
	logic [3:0][B-1:0] raw_in;
	logic [3:0][B-1:0] mag_in;
	logic [3:0][B-1:0] mag_q;
	logic [3:0]        neg_q;
	frac_kind_t        kind_q;

	assign raw_in[IX_LN] = B'($unsigned(req.left_num));
	assign raw_in[IX_LD] = B'($unsigned(req.left_den));
	assign raw_in[IX_RN] = B'($unsigned(req.right_num));
	assign raw_in[IX_RD] = B'($unsigned(req.right_den));

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_in[i] = raw_in[i][B-1] ? (~raw_in[i] + 1'b1) : raw_in[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= req.kind;
			mag_q  <= mag_in;
			for (int i = 0; i < 4; i++) neg_q[i] <= raw_in[i][B-1];
		end
	end

	// shared multiplier, one product per cycle
	logic [B-1:0] mul_a, mul_b;
	logic         mul_neg;
	logic [W-1:0] prod;
	logic [W-1:0] p_num_q, p_cross_q, p_den_q;
	logic         p_num_neg_q, p_cross_neg_q, p_den_neg_q;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_NUM: begin
				mul_a = mag_q[IX_LN];
				if (kind_q == KIND_MUL) begin
					mul_b   = mag_q[IX_RN];
					mul_neg = neg_q[IX_LN] ^ neg_q[IX_RN];
				end else begin
					mul_b   = mag_q[IX_RD];
					mul_neg = neg_q[IX_LN] ^ neg_q[IX_RD];
				end
			end
			MUL_CROSS: begin
				mul_a   = mag_q[IX_LD];
				mul_b   = mag_q[IX_RN];
				mul_neg = neg_q[IX_LD] ^ neg_q[IX_RN];
			end
			MUL_DEN: begin
				mul_a = mag_q[IX_LD];
				if (kind_q == KIND_DIV) begin
					mul_b   = mag_q[IX_RN];
					mul_neg = neg_q[IX_LD] ^ neg_q[IX_RN];
				end else begin
					mul_b   = mag_q[IX_RD];
					mul_neg = neg_q[IX_LD] ^ neg_q[IX_RD];
				end
			end
			default: begin
				mul_a   = '0;
				mul_b   = '0;
				mul_neg = 1'b0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			unique case (cmd.mul_sel)
				MUL_NUM: begin
					p_num_q     <= prod;
					p_num_neg_q <= mul_neg;
				end
				MUL_CROSS: begin
					p_cross_q     <= prod;
					p_cross_neg_q <= mul_neg;
				end
				MUL_DEN: begin
					p_den_q     <= prod;
					p_den_neg_q <= mul_neg;
				end
				default: begin
					p_num_q <= p_num_q;
				end
			endcase
		end
	end

	// signed-magnitude sum, then the denominator's sign moves to the numerator
	logic [W-1:0] sa_mag, sb_mag, s_mag;
	logic         sa_neg, sb_neg, s_neg, num_neg_nxt, addsub;

	always_comb begin
		addsub = (kind_q == KIND_ADD) || (kind_q == KIND_SUB);
		sa_mag = p_num_q;
		sa_neg = p_num_neg_q && (p_num_q != '0);
		sb_mag = addsub ? p_cross_q : '0;
		sb_neg = (p_cross_neg_q ^ (kind_q == KIND_SUB)) && (sb_mag != '0);
		if (sa_neg == sb_neg) begin
			s_mag = sa_mag + sb_mag;
			s_neg = sa_neg;
		end else if (sa_mag >= sb_mag) begin
			s_mag = sa_mag - sb_mag;
			s_neg = sa_neg;
		end else begin
			s_mag = sb_mag - sa_mag;
			s_neg = sb_neg;
		end
		num_neg_nxt = (s_neg ^ (p_den_neg_q && (p_den_q != '0))) && (s_mag != '0);
	end

	// binary GCD: b stays nonzero, common factors of two counted in k
	logic [W-1:0]  a_q, b_q;
	logic [KW-1:0] k_q;
	logic [W-1:0]  num_mag_q, den_mag_q;
	logic          num_neg_q, err_q;

	always_ff @(posedge clk) begin
		if (cmd.combine) begin
			a_q <= s_mag;
			b_q <= p_den_q;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			priority if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= (a_q - b_q) >> 1;
			end else begin
				b_q <= (b_q - a_q) >> 1;
			end
		end
	end

	// restoring division of both magnitudes by the GCD, one bit per cycle;
	// the quotient shifts into the dividend register
	logic [W-1:0]  d_q, num_rem_q, den_rem_q;
	logic [KW-1:0] cnt_q;
	logic [W:0]    n_t, dn_t, n_diff, dn_diff;
	logic          n_ge, dn_ge;

	always_comb begin
		n_t     = {num_rem_q, num_mag_q[W-1]};
		dn_t    = {den_rem_q, den_mag_q[W-1]};
		n_diff  = n_t - {1'b0, d_q};
		dn_diff = dn_t - {1'b0, d_q};
		n_ge    = n_t >= {1'b0, d_q};
		dn_ge   = dn_t >= {1'b0, d_q};
	end

	always_ff @(posedge clk) begin
		if (cmd.combine) begin
			num_mag_q <= s_mag;
			num_neg_q <= num_neg_nxt;
			den_mag_q <= p_den_q;
			err_q     <= (p_den_q == '0);
		end else if (cmd.div_step) begin
			num_mag_q <= {num_mag_q[W-2:0], n_ge};
			den_mag_q <= {den_mag_q[W-2:0], dn_ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			d_q       <= b_q << k_q;
			num_rem_q <= '0;
			den_rem_q <= '0;
			cnt_q     <= KW'(W - 1);
		end else if (cmd.div_step) begin
			num_rem_q <= n_ge ? n_diff[W-1:0] : n_t[W-1:0];
			den_rem_q <= dn_ge ? dn_diff[W-1:0] : dn_t[W-1:0];
			cnt_q     <= cnt_q - 1'b1;
		end
	end

	// output formatting with saturation
	logic [XW-1:0]    nx, dx;
	logic [NUM_W-1:0] n_sat, n_out;
	logic [DEN_W-1:0] d_out;
	frac_rsp_t        rsp_q;

	always_comb begin
		nx = XW'(num_mag_q);
		dx = XW'(den_mag_q);
		if (num_neg_q) begin
			n_sat = (nx > XW'(33'h0_8000_0000)) ? 32'h8000_0000 : nx[NUM_W-1:0];
			n_out = ~n_sat + 1'b1;
		end else begin
			n_sat = (nx > XW'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : nx[NUM_W-1:0];
			n_out = n_sat;
		end
		if (err_q) d_out = '0;
		else d_out = (dx > XW'(DEN_MAX)) ? DEN_MAX : dx[DEN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.result_num <= n_out;
			rsp_q.result_den <= d_out;
			rsp_q.status     <= err_q ? STATUS_ZERO_DEN : STATUS_OK;
		end
	end

	assign rsp           = rsp_q;
	assign stat.kind     = kind_q;
	assign stat.den_zero = (p_den_q == '0);
	assign stat.gcd_done = (a_q == '0);
	assign stat.div_last = (cnt_q == '0);

	a_gcd_b_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step |-> (b_q != '0))
		else $error("GCD operand b reached zero");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (d_q != '0))
		else $error("division started with a zero divisor");

	a_exact_division: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && !err_q) |-> (num_rem_q == '0 && den_rem_q == '0))
		else $error("reduction left a nonzero remainder");

endmodule

@@ rtl/fraction_arith_reduce_top.sv @@
// Top level of the fraction arithmetic block with GCD reduction.
`timescale 1ns / 1ps
// Takes one request of two signed fractions and an operation (add, subtract,
// multiply, divide) and returns the result reduced to lowest terms with a
// positive denominator. A zero result denominator gives status 1, den 0 and
// the unreduced numerator. One request is worked at a time: capture,
// two or three products on one shared multiplier, a combine step, a binary
// GCD of subtract/shift steps whose length depends on the data, then
// bit-serial division of numerator and denominator in parallel, and a load
// of the result register. A zero result denominator skips the GCD and the
// division. A new request is taken while the previous result still waits in
// the output register.
module fraction_arith_reduce_top import frac_pkg::*; #(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      operand_valid,
	output logic      operand_stall,
	input  frac_req_t operand,
	output logic      result_valid,
	input  logic      result_stall,
	output frac_rsp_t result
);

	frac_cmd_t  cmd;
	frac_stat_t stat;

	frac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand_valid),
		.in_stall  (operand_stall),
		.out_stall (result_stall),
		.out_valid (result_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	frac_dp #(
		.OPERAND_BITS (OPERAND_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (operand),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (result)
	);

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for fraction_arith_reduce_top: random and corner requests, reduced-fraction predictor.
`timescale 1ns / 1ps
module testbench;
	import frac_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_OPS     = 1250;
	localparam int DRAIN_CYCLES   = 200;

	typedef enum int {MIX_WIDE, MIX_SMALL, MIX_POW2, MIX_CORNER} mix_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      operand_valid = 1'b0;
	logic      operand_stall;
	frac_req_t operand = '0;
	logic      result_valid;
	logic      result_stall = 1'b0;
	frac_rsp_t result;

	frac_req_t pending_ops[$];
	frac_rsp_t expected_results[$];
	int        mismatches = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        idle_cycles = 0;
	logic [31:0] cycle_count = '0;

	fraction_arith_reduce_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.operand_valid(operand_valid),
		.operand_stall(operand_stall),
		.operand(operand),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact cross-multiply, sign to the numerator, Euclid on magnitudes, then clamp.
	function automatic frac_rsp_t reduce_fraction(frac_req_t req);
		longint ln, ld, rn, rd, num, den, a, b, r;
		frac_rsp_t rsp;
		ln = $signed(req.left_num);
		ld = $signed(req.left_den);
		rn = $signed(req.right_num);
		rd = $signed(req.right_den);
		den = ld * rd;
		case (req.kind)
			KIND_ADD: num = ln * rd + ld * rn;
			KIND_SUB: num = ln * rd - ld * rn;
			KIND_MUL: num = ln * rn;
			default: begin
				num = ln * rd;
				den = ld * rn;
			end
		endcase
		rsp.status = STATUS_OK;
		if (den == 0) begin
			rsp.status = STATUS_ZERO_DEN;
			rsp.result_den = '0;
		end else begin
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			a = (num < 0) ? -num : num;
			b = den;
			while (b != 0) begin
				r = a % b;
				a = b;
				b = r;
			end
			num = num / a;
			den = den / a;
			rsp.result_den = (den > longint'(DEN_MAX)) ? DEN_MAX : den[DEN_W-1:0];
		end
		if (num > 64'sd2147483647)
			num = 64'sd2147483647;
		else if (num < -64'sd2147483648)
			num = -64'sd2147483648;
		rsp.result_num = num[NUM_W-1:0];
		return rsp;
	endfunction

	// Mostly short gaps, a few long ones; no gaps at all while cycle_count[12:11] is zero.
	function automatic int idle_len();
		int r;
		if (cycle_count[12:11] == 2'b00)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 150);
	endfunction

	function automatic logic [FIELD_W-1:0] field_value(mix_t mix);
		int v;
		case (mix)
			MIX_WIDE: v = $urandom;
			MIX_SMALL: v = int'($urandom_range(0, 24)) - 12;
			MIX_POW2: v = (int'($urandom_range(0, 510)) - 255) <<< $urandom_range(0, 7);
			default: begin
				case ($urandom_range(0, 6))
					0: v = -32768;
					1: v = -32767;
					2: v = -1;
					3: v = 0;
					4: v = 1;
					5: v = 32767;
					default: v = $urandom;
				endcase
			end
		endcase
		return v[FIELD_W-1:0];
	endfunction

	task automatic add_op(frac_kind_t k, int ln, int ld, int rn, int rd);
		frac_req_t req;
		req.kind = k;
		req.left_num = ln[FIELD_W-1:0];
		req.left_den = ld[FIELD_W-1:0];
		req.right_num = rn[FIELD_W-1:0];
		req.right_den = rd[FIELD_W-1:0];
		pending_ops.push_back(req);
	endtask

	task automatic check_field(string field, logic signed [63:0] want, logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		logic next_valid;
		if (!arst_n) begin
			operand_valid <= 1'b0;
			operand <= '0;
			gap_left = 0;
		end else begin
			next_valid = operand_valid;
			if (operand_valid && !operand_stall) begin
				expected_results.push_back(reduce_fraction(operand));
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() != 0) begin
					operand <= pending_ops.pop_front();
					next_valid = 1'b1;
					gap_left = idle_len();
				end
			end
			operand_valid <= next_valid;
		end
	end

	// result monitor and receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		frac_rsp_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %0d/%0d status %0d",
						$time, result.result_num, result.result_den, result.status);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("result_num", want.result_num, result.result_num);
					check_field("result_den", want.result_den, result.result_den);
					check_field("status", want.status, result.status);
				end
				stall_left = idle_len();
			end else if (stall_left == 0 && $urandom_range(0, 15) == 0) begin
				stall_left = idle_len();
			end
			if (stall_left > 0) begin
				result_stall <= 1'b1;
				stall_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if ((operand_valid && !operand_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("fraction_arith_reduce_top regression: fail");
			$finish;
		end
	end

	initial begin
		mix_t mix;
		frac_req_t req;
		int i;

		// directed corners
		add_op(KIND_ADD, 1, 2, 1, 3);
		add_op(KIND_SUB, 1, 2, 1, 2);
		add_op(KIND_MUL, -3, 4, 2, -9);
		add_op(KIND_DIV, 3, 4, -6, 8);
		add_op(KIND_ADD, 5, 0, 7, 3);
		add_op(KIND_DIV, 5, 3, 0, 7);
		add_op(KIND_MUL, 4, 9, 2, 0);
		add_op(KIND_DIV, 0, 0, 0, 0);
		add_op(KIND_ADD, 32767, 32767, 32767, 32767);
		add_op(KIND_ADD, -32768, -32768, -32768, -32768);
		add_op(KIND_MUL, 1, -32768, 1, -32768);
		add_op(KIND_MUL, -1, -32768, 1, -32768);
		add_op(KIND_SUB, -32768, 1, 32767, 1);
		add_op(KIND_MUL, -32768, 1, -32768, 1);
		add_op(KIND_DIV, 32767, -32768, 0, 1);
		add_op(KIND_DIV, -32768, 1, -32768, -1);
		add_op(KIND_MUL, 0, -5, 7, 3);
		add_op(KIND_SUB, 32767, -1, -32768, 1);
		add_op(KIND_ADD, -1, -1, -1, -1);
		add_op(KIND_DIV, -32768, -32767, 32767, -32768);
		add_op(KIND_ADD, -32768, -32767, -32768, -32768);
		add_op(KIND_SUB, -32768, 32767, 32767, -32768);

		for (i = 0; i < RANDOM_OPS; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: mix = MIX_WIDE;
				4, 5, 6: mix = MIX_SMALL;
				7: mix = MIX_POW2;
				default: mix = MIX_CORNER;
			endcase
			req.kind = frac_kind_t'($urandom_range(0, 3));
			req.left_num = field_value(mix);
			req.left_den = field_value(mix);
			req.right_num = field_value(mix);
			req.right_den = field_value(mix);
			// occasional zero denominator or zero divisor
			if ($urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 2))
					0: req.left_den = '0;
					1: req.right_den = '0;
					default: req.right_num = '0;
				endcase
			end
			pending_ops.push_back(req);
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_ops.size() != 0 || operand_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("fraction_arith_reduce_top regression: pass");
		else
			$display("fraction_arith_reduce_top regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/frac_pkg.sv
rtl/frac_ctrl.sv
rtl/frac_dp.sv
rtl/fraction_arith_reduce_top.sv
bench/testbench.sv
